/* rtl/core/alar_pkg.sv */
// Package with the types, constants and lookup functions of the lux core.
`timescale 1ns / 1ps

package alar_pkg;

    localparam int ChW      = 16;
    localparam int LuxW     = 19;
    localparam int RateW    = 2;
    localparam int GainW    = 2;
    localparam int DiffW    = 25;
    localparam int DqW      = 21;
    localparam int LpcW     = 25;
    localparam int TsqW     = 12;
    localparam int GrW      = 14;
    localparam int NumW     = 32;
    localparam int QuotW    = 19;
    localparam int RemInitW = NumW - QuotW;
    localparam int CntW     = 5;
    localparam int P31W     = 21;
    localparam int P33W     = 22;

    localparam logic [LuxW-1:0]   LuxNegFill = LuxW'(30000);
    localparam logic [11:0]       LuxScale   = 12'd2496;
    localparam logic [CntW-1:0]   DivLast    = CntW'(QuotW - 1);
    localparam logic [GainW-1:0]  GainMax    = 2'd3;
    localparam logic [RateW-1:0]  RateReset  = 2'd2;
    localparam logic [RateW-1:0]  RateTop    = 2'd2;
    localparam logic [ChW-1:0]    ThrMax     = 16'hFFFF;

    typedef struct packed {
        logic            sample_valid;
        logic [ChW-1:0]  ch0_count;
        logic [ChW-1:0]  ch1_count;
    } smp_t;

    typedef struct packed {
        logic             lux_valid;
        logic [LuxW-1:0]  lux;
        logic [GainW-1:0] gain_index_out;
        logic             low_gain_out;
        logic             thresholds_valid;
        logic [ChW-1:0]   low_threshold;
        logic [ChW-1:0]   high_threshold;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } st_t;

    function automatic logic [RateW-1:0] rate_code(input logic [RateW-1:0] r);
        return (r > RateTop) ? RateTop : r;
    endfunction

    function automatic logic [TsqW-1:0] time_quarter(input logic [RateW-1:0] r);
        logic [TsqW-1:0] v;
        unique case (r)
            2'd0:    v = 12'd680;
            2'd1:    v = 12'd1292;
            default: v = 12'd2516;
        endcase
        return v;
    endfunction

    function automatic logic [GrW-1:0] gain_red(input logic [GainW-1:0] g,
                                                input logic reduced);
        logic [GrW-1:0] v;
        unique case (g)
            2'd0:    v = reduced ? 14'd16   : 14'd100;
            2'd1:    v = reduced ? 14'd128  : 14'd800;
            2'd2:    v = reduced ? 14'd256  : 14'd1600;
            default: v = reduced ? 14'd1920 : 14'd12000;
        endcase
        return v;
    endfunction

    function automatic logic [ChW-1:0] lim_lo(input logic [RateW-1:0] r);
        logic [ChW-1:0] v;
        unique case (r)
            2'd0:    v = 16'd1024;
            2'd1:    v = 16'd1945;
            default: v = 16'd3788;
        endcase
        return v;
    endfunction

    function automatic logic [ChW-1:0] lim_hi(input logic [RateW-1:0] r);
        logic [ChW-1:0] v;
        unique case (r)
            2'd0:    v = 16'd9216;
            2'd1:    v = 16'd17511;
            default: v = 16'd34100;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/ambient_light_autorange_lux_core.sv */
// Lux estimator with automatic gain ranging and a bit-serial divider.
`timescale 1ns / 1ps

// The block takes one request of two channel counts on smp (smp_valid and
// smp_ready) and returns exactly one result on res (res_valid and res_ready).
// The user must write the integration time code on cfg only while the block is idle; the block does not enforce it.
// A request with sample_valid low, or with a negative channel difference,
// skips the divider and goes from the prepare step to the final step.
// Otherwise the lux value comes from a restoring divider that retires one
// quotient bit per cycle, after the prepare and scale steps.
// The block takes one request at a time; smp_ready is high only while the
// sequencer is idle, which is in the cycle after a result is handed over.
// A finished result sits in the output register until it is taken, and the
// next request may be accepted meanwhile; that request waits in its final
// step until the output register is free, so a stalled receiver never loses
// or repeats a result.
// Reset clears the gain index and the low-gain flag, sets the integration
// time code to its longest setting and empties the output register.
module ambient_light_autorange_lux_core
    import alar_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             smp_valid,
    output logic             smp_ready,
    input  smp_t             smp,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [RateW-1:0] cfg_data
);

    st_t              state_reg, state_next;
    logic [RateW-1:0] rate_reg;
    logic [GainW-1:0] gain_reg, gain_next;
    logic             reduced_reg, reduced_next;
    logic             res_valid_reg;
    res_t             res_reg;

    smp_t             smp_reg;
    logic [DqW-1:0]   dq_reg, dq_next;
    logic [LpcW-1:0]  lpc_reg, lpc_next;
    logic [LpcW-1:0]  rem_reg, rem_next;
    logic [QuotW-1:0] low_reg, low_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             lux_ok_reg, lux_ok_next;
    logic [LuxW-1:0]  lux_reg, lux_next;
    logic             th_ok_reg, th_ok_next;
    logic [ChW-1:0]   th_lo_reg, th_lo_next;
    logic [ChW-1:0]   th_hi_reg, th_hi_next;

    logic             take_smp;
    logic             load_res;
    logic             neg_d;

    logic [RateW-1:0]       rc;
    logic signed [DiffW-1:0] d1, d2, dmax;
    logic [TsqW+GrW-1:0]    lpc_prod;
    logic [NumW-1:0]        num;
    logic [P31W-1:0]        p31;
    logic [P33W-1:0]        p33;
    logic [LpcW:0]          trial, diff;
    logic                   ge;

    assign rc       = rate_code(rate_reg);
    assign d1       = $signed({9'd0, smp_reg.ch0_count}) * $signed(25'd100)
                    - $signed({9'd0, smp_reg.ch1_count}) * $signed(25'd223);
    assign d2       = $signed({9'd0, smp_reg.ch0_count}) * $signed(25'd70)
                    - $signed({9'd0, smp_reg.ch1_count}) * $signed(25'd142);
    assign dmax     = (d1 > d2) ? d1 : d2;
    assign neg_d    = dmax[DiffW-1];
    assign lpc_prod = time_quarter(rc) * gain_red(gain_reg, reduced_reg);
    assign num      = {11'd0, dq_reg} * {20'd0, LuxScale};
    assign p31      = {5'd0, smp_reg.ch0_count} * 21'd31;
    assign p33      = {6'd0, smp_reg.ch0_count} * 22'd33;
    assign trial    = {rem_reg, low_reg[QuotW-1]};
    assign diff     = trial - {1'b0, lpc_reg};
    assign ge       = (trial >= {1'b0, lpc_reg});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (smp_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (smp_reg.sample_valid && !neg_d)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DivLast)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        smp_ready = (state_reg == ST_IDLE);
        take_smp  = (state_reg == ST_IDLE) && smp_valid;
        load_res  = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);
    end

    // Datapath next values.
    always_comb
    begin
        gain_next    = gain_reg;
        reduced_next = reduced_reg;
        dq_next      = dq_reg;
        lpc_next     = lpc_reg;
        rem_next     = rem_reg;
        low_next     = low_reg;
        cnt_next     = cnt_reg;
        lux_ok_next  = lux_ok_reg;
        lux_next     = lux_reg;
        th_ok_next   = th_ok_reg;
        th_lo_next   = th_lo_reg;
        th_hi_next   = th_hi_reg;
        unique case (state_reg)
            ST_PREP:
            begin
                lux_ok_next = 1'b0;
                lux_next    = '0;
                th_ok_next  = 1'b0;
                th_lo_next  = '0;
                th_hi_next  = '0;
                dq_next     = dmax[DqW+1:2];
                lpc_next    = lpc_prod[LpcW-1:0];
                if (smp_reg.sample_valid)
                begin
                    if (neg_d)
                    begin
                        lux_ok_next = reduced_reg;
                        lux_next    = reduced_reg ? LuxNegFill : '0;
                    end
                    else
                    begin
                        lux_ok_next = 1'b1;
                    end
                    th_ok_next = 1'b0;
                    priority if (smp_reg.ch0_count > lim_hi(rc))
                    begin
                        priority if (gain_reg != '0)
                            gain_next = gain_reg - 2'd1;
                        else if (!reduced_reg)
                            reduced_next = 1'b1;
                        else
                            th_ok_next = 1'b1;
                    end
                    else if (smp_reg.ch0_count < lim_lo(rc))
                    begin
                        priority if (reduced_reg)
                            reduced_next = 1'b0;
                        else if (gain_reg != GainMax)
                            gain_next = gain_reg + 2'd1;
                        else
                            th_ok_next = 1'b1;
                    end
                    else
                    begin
                        th_ok_next = 1'b1;
                    end
                    if (th_ok_next)
                    begin
                        th_lo_next = p31[P31W-1:5];
                        th_hi_next = p33[P33W-1] ? ThrMax : p33[P33W-2:5];
                    end
                end
            end
            ST_SCALE:
            begin
                rem_next = {{(LpcW-RemInitW){1'b0}}, num[NumW-1:QuotW]};
                low_next = num[QuotW-1:0];
                cnt_next = '0;
            end
            ST_DIV:
            begin
                rem_next = ge ? diff[LpcW-1:0] : trial[LpcW-1:0];
                low_next = {low_reg[QuotW-2:0], ge};
                cnt_next = cnt_reg + CntW'(1);
                if (cnt_reg == DivLast)
                begin
                    lux_next = {low_reg[QuotW-2:0], ge};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RateReset;
            gain_reg      <= '0;
            reduced_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            reduced_reg <= reduced_next;
            if (cfg_valid)
            begin
                rate_reg <= cfg_data;
            end
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_smp)
        begin
            smp_reg <= smp;
        end
        dq_reg     <= dq_next;
        lpc_reg    <= lpc_next;
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        cnt_reg    <= cnt_next;
        lux_ok_reg <= lux_ok_next;
        lux_reg    <= lux_next;
        th_ok_reg  <= th_ok_next;
        th_lo_reg  <= th_lo_next;
        th_hi_reg  <= th_hi_next;
        if (load_res)
        begin
            res_reg.lux_valid        <= lux_ok_reg;
            res_reg.lux              <= lux_reg;
            res_reg.gain_index_out   <= gain_reg;
            res_reg.low_gain_out     <= reduced_reg;
            res_reg.thresholds_valid <= th_ok_reg;
            res_reg.low_threshold    <= th_lo_reg;
            res_reg.high_threshold   <= th_hi_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The partial remainder always stays below the divisor.
    a_rem_below_lpc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < lpc_reg))
        else $error("divider remainder reached the divisor");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= DivLast))
        else $error("divider step count out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (smp_valid && smp_ready) |=> (state_reg == ST_PREP))
        else $error("accepted request did not start the sequencer");

    a_lux_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.lux_valid) |-> (res.lux == '0))
        else $error("lux not cleared while unreported");

    a_thr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.thresholds_valid) |-> (res.high_threshold >= res.low_threshold))
        else $error("upper threshold below lower threshold");

    a_thr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.thresholds_valid)
            |-> (res.low_threshold == '0 && res.high_threshold == '0))
        else $error("thresholds not cleared while unreported");

endmodule

/* dv/ambient_light_autorange_lux_core_tb.sv */
// Self-checking testbench for the lux core with its own gain-ranging predictor.
`timescale 1ns / 1ps

module ambient_light_autorange_lux_core_tb;
    import alar_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int END_DRAIN   = 40;
    localparam int MAX_REPORTS = 10;

    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    localparam logic [RateW-1:0] RATE_SHORT  = 2'd0;
    localparam logic [RateW-1:0] RATE_MID    = 2'd1;
    localparam logic [RateW-1:0] RATE_LONG   = 2'd2;
    localparam logic [RateW-1:0] RATE_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             smp_valid = 1'b0;
    logic             smp_ready;
    smp_t             smp = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    res_t             res;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [RateW-1:0] cfg_data = '0;

    smp_t pend_q[$];
    res_t lux_expect_q[$];

    logic [RateW-1:0] rate_shadow = RateReset;
    logic [GainW-1:0] model_gain = '0;
    logic             model_reduced = 1'b0;
    int               idle_mode = IDLE_NONE;

    int req_queued = 0;
    int req_accepted = 0;
    int results_checked = 0;
    int fail_count = 0;
    int thr_updates = 0;
    int neg_fills = 0;
    int cycle_count = 0;

    ambient_light_autorange_lux_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp       (smp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_rate(input logic [RateW-1:0] r);
        return (r > 2'd2) ? 2 : int'(r);
    endfunction

    function automatic int full_count(input int rc);
        int v;
        case (rc)
            0:       v = 10240;
            1:       v = 19456;
            default: v = 37888;
        endcase
        return v;
    endfunction

    function automatic res_t predict_lux_result(input smp_t s);
        res_t   r;
        int     ch0, ch1, d1, d2, d, rc, full, lo, hi, ts, gf, red;
        longint lpc, num;
        r = '0;
        if (s.sample_valid)
        begin
            ch0 = int'(s.ch0_count);
            ch1 = int'(s.ch1_count);
            d1 = ch0 * 100 - 223 * ch1;
            d2 = 70 * ch0 - 142 * ch1;
            d = (d1 > d2) ? d1 : d2;
            rc = clamp_rate(rate_shadow);
            full = full_count(rc);
            lo = full * 10 / 100;
            hi = full - lo;
            case (rc)
                0:       ts = 2720;
                1:       ts = 5168;
                default: ts = 10064;
            endcase
            case (model_gain)
                2'd0:    gf = 1;
                2'd1:    gf = 8;
                2'd2:    gf = 16;
                default: gf = 120;
            endcase
            red = model_reduced ? 16 : 100;
            lpc = (longint'(ts) * gf * red) >>> 2;
            if (d < 0)
            begin
                if (model_reduced)
                begin
                    r.lux_valid = 1'b1;
                    r.lux = LuxW'(30000);
                    neg_fills++;
                end
            end
            else
            begin
                num = longint'(d >>> 2) * 48 * 52;
                r.lux_valid = 1'b1;
                r.lux = LuxW'(num / lpc);
            end
            if (ch0 > hi)
            begin
                if (model_gain > 0)
                    model_gain = model_gain - 1'b1;
                else if (!model_reduced)
                    model_reduced = 1'b1;
                else
                    r.thresholds_valid = 1'b1;
            end
            else if (ch0 < lo)
            begin
                if (model_reduced)
                    model_reduced = 1'b0;
                else if (model_gain < 3)
                    model_gain = model_gain + 1'b1;
                else
                    r.thresholds_valid = 1'b1;
            end
            else
            begin
                r.thresholds_valid = 1'b1;
            end
            if (r.thresholds_valid)
            begin
                r.low_threshold = ChW'((ch0 * 31) >> 5);
                r.high_threshold = ((ch0 * 33) >> 5) > 65535 ? 16'hFFFF
                                                            : ChW'((ch0 * 33) >> 5);
                thr_updates++;
            end
        end
        r.gain_index_out = model_gain;
        r.low_gain_out = model_reduced;
        return r;
    endfunction

    function automatic bit roll_idle(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic string fmt_res(input res_t r);
        return $sformatf("lux_valid=%0b lux=%0d gain=%0d low_gain=%0b thr_valid=%0b %s",
                         r.lux_valid, r.lux, r.gain_index_out, r.low_gain_out,
                         r.thresholds_valid,
                         $sformatf("lo=%0d hi=%0d", r.low_threshold, r.high_threshold));
    endfunction

    // Request driver: presents queued samples and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        int pct;
        if (rst_n)
        begin
            if (smp_valid && smp_ready)
            begin
                lux_expect_q.push_back(predict_lux_result(smp));
                req_accepted++;
            end
            if (!smp_valid || smp_ready)
            begin
                pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 9 : 0;
                if (pend_q.size() > 0 && !roll_idle(pct))
                begin
                    smp_valid <= 1'b1;
                    smp <= pend_q.pop_front();
                end
                else
                begin
                    smp_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        res_t exp_r;
        int   pct;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (lux_expect_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Unexpected result: %s", fmt_res(res));
                end
                else
                begin
                    exp_r = lux_expect_q.pop_front();
                    results_checked++;
                    if (res.lux_valid !== exp_r.lux_valid || res.lux !== exp_r.lux ||
                        res.gain_index_out !== exp_r.gain_index_out ||
                        res.low_gain_out !== exp_r.low_gain_out ||
                        res.thresholds_valid !== exp_r.thresholds_valid ||
                        res.low_threshold !== exp_r.low_threshold ||
                        res.high_threshold !== exp_r.high_threshold)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("Mismatch on result %0d", results_checked);
                            $display("  expected %s", fmt_res(exp_r));
                            $display("  actual   %s", fmt_res(res));
                        end
                    end
                end
            end
            pct = (idle_mode == IDLE_RECEIVER) ? 88 : (idle_mode == IDLE_BOTH) ? 9 : 0;
            res_ready <= !roll_idle(pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_sample(input logic v, input int ch0, input int ch1);
        smp_t s;
        s.sample_valid = v;
        s.ch0_count = ChW'(ch0);
        s.ch1_count = ChW'(ch1);
        pend_q.push_back(s);
        req_queued++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pend_q.size() != 0 || req_accepted != req_queued || lux_expect_q.size() != 0);
    endtask

    task automatic write_rate(input logic [RateW-1:0] code);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_shadow = code;
    endtask

    // Bursts of samples at one light level so the gain walks to its end stops.
    task automatic queue_random(input int n_valid);
        int added, level, burst, rc, lo, hi, ch0, ch1, pick;
        added = 0;
        while (added < n_valid)
        begin
            rc = clamp_rate(rate_shadow);
            lo = full_count(rc) * 10 / 100;
            hi = full_count(rc) - lo;
            level = $urandom_range(0, 4);
            burst = $urandom_range(1, 10);
            repeat (burst)
            begin
                case (level)
                    0:       ch0 = $urandom_range(0, 65535);
                    1:       ch0 = $urandom_range(0, lo - 1);
                    2:       ch0 = $urandom_range(lo, hi);
                    3:       ch0 = $urandom_range(hi + 1, 65535);
                    default: ch0 = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 6) - 3;
                endcase
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    ch1 = $urandom_range(0, 65535);
                else if (pick < 8)
                    ch1 = $urandom_range(0, ch0 * 2 / 5);
                else
                    ch1 = $urandom_range(ch0 * 2 / 5, (ch0 / 2 + 1 > 65535) ? 65535 : ch0 / 2 + 1);
                if (roll_idle(8))
                begin
                    queue_sample(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535));
                end
                else
                begin
                    queue_sample(1'b1, ch0, ch1);
                    added++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [RateW-1:0] code, input int mode, input int n_valid);
        idle_mode = IDLE_NONE;
        write_rate(code);
        idle_mode = mode;
        queue_random(n_valid / 2);
        wait_drained();
        queue_random(n_valid - n_valid / 2);
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk at the reset integration time through every gain step.
        queue_sample(1'b0, 65535, 65535);
        queue_sample(1'b1, 0, 0);
        queue_sample(1'b1, 0, 65535);
        queue_sample(1'b1, 100, 0);
        queue_sample(1'b1, 1000, 10);
        queue_sample(1'b1, 3788, 0);
        queue_sample(1'b1, 34100, 0);
        queue_sample(1'b1, 34101, 0);
        queue_sample(1'b1, 65535, 0);
        queue_sample(1'b1, 65535, 0);
        queue_sample(1'b1, 65535, 65535);
        queue_sample(1'b1, 65535, 0);
        queue_sample(1'b1, 65535, 65535);
        queue_sample(1'b1, 1, 0);
        queue_sample(1'b0, 0, 0);
        queue_sample(1'b1, 16'h5555, 16'hAAAA);
        queue_sample(1'b1, 16'hAAAA, 16'h5555);
        queue_sample(1'b1, 3787, 1000);
        wait_drained();

        // Shortest integration time with reduced gain gives the largest lux.
        write_rate(RATE_SHORT);
        queue_sample(1'b1, 65535, 0);
        queue_sample(1'b1, 65535, 0);
        queue_sample(1'b1, 65535, 0);
        queue_sample(1'b1, 65535, 65535);
        wait_drained();

        run_phase(RATE_SHORT,  IDLE_NONE,     126);
        run_phase(RATE_MID,    IDLE_SENDER,   126);
        run_phase(RATE_UNUSED, IDLE_RECEIVER, 126);
        run_phase(RATE_LONG,   IDLE_BOTH,     126);
        run_phase(RATE_SHORT,  IDLE_RECEIVER, 126);
        run_phase(RATE_MID,    IDLE_BOTH,     126);
        run_phase(RATE_LONG,   IDLE_SENDER,   126);
        run_phase(RATE_UNUSED, IDLE_NONE,     126);

        idle_mode = IDLE_NONE;
        wait_drained();
        repeat (END_DRAIN) @(posedge clk);

        if (lux_expect_q.size() != 0)
        begin
            fail_count++;
            $display("%0d predicted results never arrived", lux_expect_q.size());
        end
        $display("Checked %0d results from %0d requests with %0d failures.",
                 results_checked, req_accepted, fail_count);
        $display("Integration codes 0 to 3 under four timing mixes; %0d %s %0d %s",
                 thr_updates, "threshold updates,", neg_fills, "negative fills.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
